// ===== rtl/dcwa_pkg.sv =====
package dcwa_pkg;

  // Field widths of the sample and the window registers
  localparam int unsigned SampleW = 32;
  localparam int unsigned WinW    = 6;

  // Configuration register indexes
  localparam logic REG_WINDOW_CH0 = 1'b0;
  localparam logic REG_WINDOW_CH1 = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ACC  = 6'b000010,
    ST_ABS  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_FIX  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

endpackage

// ===== rtl/dual_channel_window_average.sv =====
// Two-channel moving-average filter.
// Input stream: each beat carries one signed 32-bit sample (tdata) and its
// channel number (tuser). The sample is stored in that channel's ring of
// DEPTH slots, and one output beat returns the truncated mean of the newest
// min(window, samples seen) samples of the channel, with the channel in tuser.
// Windows are set through the write port (index 0: channel 0, index 1:
// channel 1), six bits each, clamped to 1..DEPTH; a new window applies from
// the next sample of that channel.
// One adder serves accumulation, sign handling and a restoring divide.
// An item passes the states ACC, ABS, DIV, FIX and DONE in turn: the
// accumulation reads one ring slot of the effective window per cycle from
// the single read port, and the divide retires one quotient bit per cycle.
// s_axis_tready is high only while the sequencer is idle; one item is in
// work at a time. A finished mean waits in the output register, and the
// next item is accepted meanwhile; if the receiver still stalls when that
// item is done, the sequencer holds its result until the register frees.
// Reset clears write positions, sample counts and the output valid, and sets
// both windows to 1. Ring contents need no clearing: a slot is read only
// after it has been written.
module dual_channel_window_average #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic                         cfg_addr_i,
  input  logic [dcwa_pkg::WinW-1:0]    cfg_wdata_i,
  // sample stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [dcwa_pkg::SampleW-1:0] s_axis_tdata,   // [31:0] sample
  input  logic                         s_axis_tuser,   // [0] channel
  // mean stream out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [dcwa_pkg::SampleW-1:0] m_axis_tdata,   // [31:0] mean
  output logic                         m_axis_tuser    // [0] out_channel
);
  import dcwa_pkg::*;

  localparam int unsigned PW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SW  = SampleW + $clog2(DEPTH);
  localparam int unsigned STW = $clog2(SW + 1);
  localparam int unsigned MemEntries = 2 ** (PW + 1);

  localparam logic [PW-1:0]  PosLast  = PW'(DEPTH - 1);
  localparam logic [CW-1:0]  DepthC   = CW'(DEPTH);
  localparam logic [WinW:0]  DepthWin = (WinW + 1)'(DEPTH);
  localparam logic [STW-1:0] StepLast = STW'(SW - 1);

  state_e state_q, state_d;

  logic [WinW-1:0] win_cfg_q [2];
  logic [PW-1:0]   wpos_q    [2];
  logic [CW-1:0]   vcnt_q    [2];

  logic            ch_q, ch_d;
  logic [CW-1:0]   win_q, win_d;
  logic [CW-1:0]   iss_q, iss_d;
  logic [PW-1:0]   ridx_q, ridx_d;
  logic            rvalid_q, rvalid_d;
  logic [STW-1:0]  step_q, step_d;
  logic [SW-1:0]   sum_q, sum_d;
  logic [CW-1:0]   rem_q, rem_d;
  logic            neg_q, neg_d;

  logic                out_valid_q;
  logic                out_ch_q;
  logic [SampleW-1:0]  out_mean_q;
  logic                out_load;

  logic [SampleW-1:0]  ring_mem [MemEntries];
  logic [SampleW-1:0]  rdata_q;
  logic                rd_en;
  logic [PW:0]         rd_addr;

  logic                accept;
  logic [PW-1:0]       pos_cur;
  logic [CW-1:0]       vc_new;
  logic [WinW:0]       win_raw;
  logic [WinW:0]       win_clamp;
  logic [CW-1:0]       win_eff;

  logic [SW:0]         alu_a, alu_b, alu_s;
  logic                alu_ci;
  logic [CW:0]         rem_sh;
  logic                div_ge;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Window for the arriving sample: clamp to 1..DEPTH, then to samples seen
  assign pos_cur = wpos_q[s_axis_tuser];
  assign vc_new  = (vcnt_q[s_axis_tuser] < DepthC) ? vcnt_q[s_axis_tuser] + CW'(1)
                                                   : vcnt_q[s_axis_tuser];
  assign win_raw = {1'b0, win_cfg_q[s_axis_tuser]};
  always_comb begin
    win_clamp = win_raw;
    if (win_raw == '0) begin
      win_clamp = (WinW + 1)'(1);
    end else if (win_raw > DepthWin) begin
      win_clamp = DepthWin;
    end
    win_eff = (CW'(win_clamp) < vc_new) ? CW'(win_clamp) : vc_new;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q[0] <= WinW'(1);
      win_cfg_q[1] <= WinW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_WINDOW_CH0: win_cfg_q[0] <= cfg_wdata_i;
        REG_WINDOW_CH1: win_cfg_q[1] <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Per-channel write position and sample count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q[0] <= '0;
      wpos_q[1] <= '0;
      vcnt_q[0] <= '0;
      vcnt_q[1] <= '0;
    end else if (accept) begin
      wpos_q[s_axis_tuser] <= (pos_cur == PosLast) ? '0 : pos_cur + PW'(1);
      vcnt_q[s_axis_tuser] <= vc_new;
    end
  end

  // Sample ring: write on accept, registered read during accumulation
  assign rd_en   = (state_q == ST_ACC) && (iss_q < win_q);
  assign rd_addr = {ch_q, ridx_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_mem[{s_axis_tuser, pos_cur}] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= ring_mem[rd_addr];
    end
  end

  // Shared adder: accumulate, negate, trial subtract
  assign alu_s  = alu_a + alu_b + (SW + 1)'(alu_ci);
  assign rem_sh = {rem_q, sum_q[SW-1]};
  assign div_ge = !alu_s[SW];

  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_ci = 1'b0;
    unique case (state_q)
      ST_ACC: begin
        alu_a = {sum_q[SW-1], sum_q};
        alu_b = (SW + 1)'(signed'(rdata_q));
      end
      ST_ABS, ST_FIX: begin
        alu_b  = ~{1'b0, sum_q};
        alu_ci = 1'b1;
      end
      ST_DIV: begin
        alu_a  = {(SW - CW)'(0), rem_sh};
        alu_b  = ~{(SW + 1 - CW)'(0), win_q};
        alu_ci = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    win_d    = win_q;
    iss_d    = iss_q;
    ridx_d   = ridx_q;
    rvalid_d = 1'b0;
    step_d   = step_q;
    sum_d    = sum_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ch_d    = s_axis_tuser;
          win_d   = win_eff;
          iss_d   = '0;
          ridx_d  = pos_cur;
          sum_d   = '0;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        // issue one read per cycle walking back from the newest slot
        if (rd_en) begin
          iss_d    = iss_q + CW'(1);
          ridx_d   = (ridx_q == '0) ? PosLast : ridx_q - PW'(1);
          rvalid_d = 1'b1;
        end
        if (rvalid_q) begin
          sum_d = alu_s[SW-1:0];
        end else if (!rd_en) begin
          state_d = ST_ABS;
        end
      end
      ST_ABS: begin
        neg_d   = sum_q[SW-1];
        sum_d   = sum_q[SW-1] ? alu_s[SW-1:0] : sum_q;
        rem_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // one quotient bit per cycle, shifted in where the dividend leaves
        rem_d  = div_ge ? alu_s[CW-1:0] : rem_sh[CW-1:0];
        sum_d  = {sum_q[SW-2:0], div_ge};
        step_d = step_q + STW'(1);
        if (step_q == StepLast) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (neg_q) begin
          sum_d = alu_s[SW-1:0];
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    win_q  <= win_d;
    iss_q  <= iss_d;
    ridx_q <= ridx_d;
    step_q <= step_d;
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_mean_q <= sum_q[SampleW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_mean_q;
  assign m_axis_tuser  = out_ch_q;

  // Checks
  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (win_q != '0 && win_q <= DepthC))
    else $error("effective window outside 1..DEPTH");

  a_vcnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vcnt_q[0] <= DepthC && vcnt_q[1] <= DepthC))
    else $error("sample count above DEPTH");

  a_iss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (iss_q <= win_q))
    else $error("more ring reads than window");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && step_q == StepLast) |=> (state_q == ST_FIX))
    else $error("divide did not finish after its last step");

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dcwa_pkg::*;

  localparam int unsigned DEPTH      = 32;
  localparam int          QUIET_MAX  = 4000;
  localparam int          RAND_ITEMS = 108;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  // One directed step: a window write or a sample, with an optional fixed mean
  typedef struct packed {
    row_kind_e   kind;
    logic        sel;       // channel, or register index for a write
    logic [31:0] value;     // sample, or window value
    logic        has_mean;
    logic [31:0] mean;
  } dir_row_t;

  typedef struct {
    logic        ch;
    logic [31:0] mean;
  } mean_beat_t;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic                 cfg_addr_i  = REG_WINDOW_CH0;
  logic [WinW-1:0]      cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SampleW-1:0]   s_axis_tdata  = '0;   // [31:0] sample
  logic                 s_axis_tuser  = 1'b0; // [0] channel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SampleW-1:0]   m_axis_tdata;         // [31:0] mean
  logic                 m_axis_tuser;         // [0] out_channel

  // Fixed mean that travels beside the current input beat
  logic                 beat_has_mean = 1'b0;
  logic [31:0]          beat_mean     = '0;

  int tx_idle_pct = 20;
  int rx_idle_pct = 73;

  // Shadow state of both channels
  logic [31:0]   ring_shadow [2][DEPTH];
  int            wr_slot [2]    = '{0, 0};
  int            fill_level [2] = '{0, 0};
  logic [5:0]    window_shadow [2] = '{6'd1, 6'd1};

  mean_beat_t    mean_q [$];
  int            err_count  = 0;
  int            samples_in = 0;
  int            means_out  = 0;
  int            cfg_writes = 0;
  int            quiet_cycles = 0;

  dir_row_t dir_rows [22] = '{
    '{ROW_SAMPLE, 1'b0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{ROW_SAMPLE, 1'b1, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, 1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000},
    // zero window behaves as one
    '{ROW_CFG,    REG_WINDOW_CH0, 32'd0, 1'b0, 32'h0},
    '{ROW_SAMPLE, 1'b0, 32'h0000_0005, 1'b1, 32'h0000_0005},
    // window above the ring depth, and above the samples seen so far
    '{ROW_CFG,    REG_WINDOW_CH1, 32'd63, 1'b0, 32'h0},
    '{ROW_SAMPLE, 1'b1, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 1'b1, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_CFG,    REG_WINDOW_CH0, 32'd2, 1'b0, 32'h0},
    '{ROW_SAMPLE, 1'b0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, 1'b0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    // truncation toward zero on both signs
    '{ROW_CFG,    REG_WINDOW_CH1, 32'd2, 1'b0, 32'h0},
    '{ROW_SAMPLE, 1'b1, 32'hFFFF_FFFD, 1'b0, 32'h0},
    '{ROW_SAMPLE, 1'b1, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, 1'b1, 32'h0000_0003, 1'b1, 32'h0000_0001},
    // ring contents survive a window change
    '{ROW_CFG,    REG_WINDOW_CH0, 32'd63, 1'b0, 32'h0},
    '{ROW_SAMPLE, 1'b0, 32'hFFFF_FFF9, 1'b0, 32'h0},
    '{ROW_CFG,    REG_WINDOW_CH1, 32'd1, 1'b0, 32'h0},
    '{ROW_SAMPLE, 1'b1, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, 1'b0, 32'hAAAA_AAAA, 1'b0, 32'h0},
    '{ROW_SAMPLE, 1'b0, 32'h5555_5555, 1'b0, 32'h0}
  };

  dual_channel_window_average #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Store the sample, advance the ring and return the truncated window mean
  function automatic logic [31:0] advance_window_mean(logic ch, logic [31:0] smp);
    int     win;
    int     slot;
    longint acc;
    win = int'(window_shadow[ch]);
    if (win < 1) win = 1;
    if (win > DEPTH) win = DEPTH;
    ring_shadow[ch][wr_slot[ch]] = smp;
    wr_slot[ch] = (wr_slot[ch] + 1 == DEPTH) ? 0 : wr_slot[ch] + 1;
    if (fill_level[ch] < DEPTH) fill_level[ch]++;
    if (win > fill_level[ch]) win = fill_level[ch];
    acc  = 0;
    slot = wr_slot[ch];
    for (int k = 0; k < win; k++) begin
      slot = (slot == 0) ? DEPTH - 1 : slot - 1;
      acc += longint'($signed(ring_shadow[ch][slot]));
    end
    acc = acc / longint'(win);
    return acc[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_count++;
    $display("[%0t] mismatch: %s expected %h got %h", $realtime, what, want, got);
  endtask

  // Offer one sample beat, idling at random first, and hold until accepted
  task automatic send_sample(logic ch, logic [31:0] smp, logic has_mean,
                             logic [31:0] mean);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= ch;
    beat_has_mean <= has_mean;
    beat_mean     <= mean;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drain every pending mean, then write one window register
  task automatic write_window(logic addr, logic [WinW-1:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (mean_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] v;
    int          mode;
    mode = $urandom_range(9);
    if (mode == 0) begin
      case ($urandom_range(3))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = 32'h0000_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end else if (mode < 4) begin
      v = 32'($urandom_range(200)) - 32'd100;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Receiver: stall at random per the current profile
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Track window writes, predict on accepted samples, check accepted means
  always @(posedge clk_i) begin
    mean_beat_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        window_shadow[cfg_addr_i] = cfg_wdata_i;
        cfg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want.ch   = s_axis_tuser;
        want.mean = advance_window_mean(s_axis_tuser, s_axis_tdata);
        if (beat_has_mean) want.mean = beat_mean;
        mean_q.push_back(want);
        samples_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        means_out++;
        if (mean_q.size() == 0) begin
          report_mismatch("mean beat with nothing pending", 32'h0, m_axis_tdata);
        end else begin
          want = mean_q.pop_front();
          if (m_axis_tuser !== want.ch)
            report_mismatch("out_channel", 32'(want.ch), 32'(m_axis_tuser));
          if (m_axis_tdata !== want.mean)
            report_mismatch("mean", want.mean, m_axis_tdata);
        end
      end
    end
  end

  // Abort when no beat and no write moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("[%0t] watchdog: no progress, %0d means pending", $realtime, mean_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int win_sets [6][2];
    win_sets = '{'{0, 63}, '{32, 1}, '{63, 7}, '{2, 33}, '{0, 0}, '{0, 0}};
    for (int s = 4; s < 6; s++) begin
      win_sets[s][0] = $urandom_range(63);
      win_sets[s][1] = $urandom_range(63);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_window(dir_rows[i].sel, dir_rows[i].value[WinW-1:0]);
      else
        send_sample(dir_rows[i].sel, dir_rows[i].value, dir_rows[i].has_mean,
                    dir_rows[i].mean);
    end

    // Random samples under three idle profiles, two window settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 20; rx_idle_pct = 73; end
        1:       begin tx_idle_pct = 73; rx_idle_pct = 20; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        write_window(REG_WINDOW_CH0, WinW'(win_sets[ph*2+seg][0]));
        write_window(REG_WINDOW_CH1, WinW'(win_sets[ph*2+seg][1]));
        repeat (RAND_ITEMS) send_sample(1'($urandom_range(1)), pick_sample(), 1'b0, 32'h0);
      end
    end

    // Drop valid, drain, then let the block settle
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (mean_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("run covered %0d samples and %0d means over %0d window writes",
             samples_in, means_out, cfg_writes);
    $display("idle profiles: sender-heavy, receiver-heavy, none; %0d mismatches",
             err_count);
    if (err_count == 0 && mean_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
